>>> hdl/red_pixel_centroid_steering_defines.svh
// Assertion macros used by the RTL back end (rpcs_back). They expect clk and rst in scope.
`ifndef RED_PIXEL_CENTROID_STEERING_DEFINES_SVH
`define RED_PIXEL_CENTROID_STEERING_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RPCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpcs assertion failed");

// Next-cycle implication, checked out of reset.
`define RPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpcs assertion failed");

`endif

>>> hdl/rpcs_pkg.sv
package rpcs_pkg;

  localparam int MARGIN_W      = 8;
  localparam int FRAME_WIDTH_W = 11;
  localparam int LIMIT_W       = 10;
  localparam int COORD_W       = 10;
  localparam int TALLY_W       = 21;
  localparam int SUM_W         = 30;
  localparam int DIR_W         = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 11;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RED_MARGIN  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_LIMIT  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_LIMIT = 2'd3;

  // Steering codes
  localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

  localparam logic [MARGIN_W-1:0]      RESET_RED_MARGIN  = 8'd51;
  localparam logic [FRAME_WIDTH_W-1:0] RESET_FRAME_WIDTH = 11'd640;
  localparam logic [LIMIT_W-1:0]       RESET_LEFT_LIMIT  = 10'd310;
  localparam logic [LIMIT_W-1:0]       RESET_RIGHT_LIMIT = 10'd311;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } pixel_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic [TALLY_W-1:0] red_count;
    logic               found;
    logic [DIR_W-1:0]   direction;
  } result_t;

  // Classification that travels with each queued pixel
  typedef struct packed {
    logic is_red;
    logic last;
  } pix_tag_t;

endpackage

>>> hdl/red_pixel_centroid_steering.sv
// Flow: a frame-end beat passes the queue and accumulator, then the shift-subtract
// divide runs and the output load raises out_valid; an empty frame skips the divide.
// Throughput: one pixel per cycle in a frame while the queue has room; a frame end halts
// accumulation for the divide and any output stall, partly absorbed by the 4-entry queue.
// Reset (rst, synchronous): clears counters, sums, queue and output valid,
// and loads register defaults 51, 640, 310, 311.
module red_pixel_centroid_steering #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rpcs_pkg::pixel_in_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rpcs_pkg::result_t                 out_data,
  input  logic                              cfg_we,
  input  logic [rpcs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rpcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rpcs_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ENTRY_W = $bits(pix_tag_t) + COL_W + ROW_W;
  localparam int Q_DEPTH = 4;

  logic [MARGIN_W-1:0]      red_margin;
  logic [FRAME_WIDTH_W-1:0] frame_width;
  logic [LIMIT_W-1:0]       left_limit, right_limit;

  logic               q_push, q_full, q_pop, q_avail;
  pix_tag_t           f_tag, b_tag;
  logic [COL_W-1:0]   f_col, b_col;
  logic [ROW_W-1:0]   f_row, b_row;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_margin  <= RESET_RED_MARGIN;
      frame_width <= RESET_FRAME_WIDTH;
      left_limit  <= RESET_LEFT_LIMIT;
      right_limit <= RESET_RIGHT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED_MARGIN:  red_margin  <= cfg_data[MARGIN_W-1:0];
        REG_FRAME_WIDTH: frame_width <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_LEFT_LIMIT:  left_limit  <= cfg_data[LIMIT_W-1:0];
        REG_RIGHT_LIMIT: right_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  rpcs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .red_margin  (red_margin),
    .frame_width (frame_width),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_tag       (f_tag),
    .q_col       (f_col),
    .q_row       (f_row)
  );

  assign q_wdata = {f_tag, f_col, f_row};
  assign {b_tag, b_col, b_row} = q_rdata;

  rpcs_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_rdata)
  );

  rpcs_back #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_avail     (q_avail),
    .q_pop       (q_pop),
    .q_tag       (b_tag),
    .q_col       (b_col),
    .q_row       (b_row),
    .left_limit  (left_limit),
    .right_limit (right_limit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> hdl/rpcs_front.sv
module rpcs_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rpcs_pkg::pixel_in_t                 in_data,
  input  logic [rpcs_pkg::MARGIN_W-1:0]       red_margin,
  input  logic [rpcs_pkg::FRAME_WIDTH_W-1:0]  frame_width,
  output logic                                q_push,
  input  logic                                q_full,
  output rpcs_pkg::pix_tag_t                  q_tag,
  output logic [COL_W-1:0]                    q_col,
  output logic [ROW_W-1:0]                    q_row
);
  import rpcs_pkg::*;

  localparam int CMP_W = ((COL_W + 1) > FRAME_WIDTH_W) ? (COL_W + 1) : FRAME_WIDTH_W;
  localparam int RCMP_W = ROW_W + 1;

  logic [COL_W-1:0]  column_index, column_index_next;
  logic [ROW_W-1:0]  row_index, row_index_next;
  logic [CMP_W-1:0]  fw_ext, width_eff, col_inc;
  logic [RCMP_W-1:0] row_inc;
  logic [MARGIN_W:0] g_lim, b_lim;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign g_lim = {1'b0, in_data.green} + {1'b0, red_margin};
  assign b_lim = {1'b0, in_data.blue} + {1'b0, red_margin};

  assign q_tag.is_red = ({1'b0, in_data.red} > g_lim) && ({1'b0, in_data.red} > b_lim);
  assign q_tag.last   = in_data.frame_end;
  assign q_col        = column_index;
  assign q_row        = row_index;

  // Clamp width into 1..MAX_WIDTH
  assign fw_ext = CMP_W'(frame_width);
  always_comb begin
    if (fw_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = fw_ext;
    end
  end

  assign col_inc = CMP_W'(column_index) + CMP_W'(1);
  assign row_inc = RCMP_W'(row_index) + RCMP_W'(1);

  always_comb begin
    column_index_next = column_index;
    row_index_next    = row_index;
    if (in_data.frame_end) begin
      column_index_next = '0;
      row_index_next    = '0;
    end else if (col_inc >= width_eff) begin
      column_index_next = '0;
      row_index_next    = (row_inc >= RCMP_W'(MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      column_index_next = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
    end else if (q_push) begin
      column_index <= column_index_next;
      row_index    <= row_index_next;
    end
  end

endmodule

>>> hdl/rpcs_fifo.sv
module rpcs_fifo #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output logic [DATA_W-1:0] pop_data
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign avail    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/rpcs_back.sv
module rpcs_back #(
  parameter int COL_W = 10,
  parameter int ROW_W = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_avail,
  output logic                          q_pop,
  input  rpcs_pkg::pix_tag_t            q_tag,
  input  logic [COL_W-1:0]              q_col,
  input  logic [ROW_W-1:0]              q_row,
  input  logic [rpcs_pkg::LIMIT_W-1:0]  left_limit,
  input  logic [rpcs_pkg::LIMIT_W-1:0]  right_limit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rpcs_pkg::result_t             out_data
);
  import rpcs_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {ACCUM, DIVIDE, DONE} state_t;

  state_t             state;
  logic [TALLY_W-1:0] pixel_tally, tally_upd;
  logic [SUM_W-1:0]   sum_columns, sum_rows, sumc_upd, sumr_upd;
  logic [SUM_W:0]     sumc_wide, sumr_wide;

  // Divider: quotient bits shift into the dividend registers
  logic [SUM_W-1:0]   dvd_x, dvd_y;
  logic [TALLY_W-1:0] rem_x, rem_y, divisor;
  logic [TALLY_W:0]   rsh_x, rsh_y;
  logic               ge_x, ge_y;
  logic [STEP_W-1:0]  step;

  logic [COORD_W-1:0] cx, cy;
  logic [DIR_W-1:0]   dir;
  logic               found, load_out;

  assign q_pop    = (state == ACCUM) && q_avail;
  assign load_out = (state == DONE) && (!out_valid || !out_stall);

  // Saturating accumulate of the popped pixel
  assign sumc_wide = {1'b0, sum_columns} + (SUM_W + 1)'(q_col);
  assign sumr_wide = {1'b0, sum_rows} + (SUM_W + 1)'(q_row);
  always_comb begin
    tally_upd = pixel_tally;
    sumc_upd  = sum_columns;
    sumr_upd  = sum_rows;
    if (q_tag.is_red) begin
      tally_upd = (&pixel_tally) ? pixel_tally : pixel_tally + TALLY_W'(1);
      sumc_upd  = sumc_wide[SUM_W] ? '1 : sumc_wide[SUM_W-1:0];
      sumr_upd  = sumr_wide[SUM_W] ? '1 : sumr_wide[SUM_W-1:0];
    end
  end

  // One restoring step per cycle for both coordinates
  assign rsh_x = {rem_x, dvd_x[SUM_W-1]};
  assign rsh_y = {rem_y, dvd_y[SUM_W-1]};
  assign ge_x  = rsh_x >= {1'b0, divisor};
  assign ge_y  = rsh_y >= {1'b0, divisor};

  // Saturate quotient and pick steering
  assign found = (divisor != '0);
  always_comb begin
    cx  = '0;
    cy  = '0;
    dir = DIR_NONE;
    if (found) begin
      cx = (|dvd_x[SUM_W-1:COORD_W]) ? '1 : dvd_x[COORD_W-1:0];
      cy = (|dvd_y[SUM_W-1:COORD_W]) ? '1 : dvd_y[COORD_W-1:0];
      if (cx != '0 && cy != '0) begin
        if (cx < left_limit) begin
          dir = DIR_LEFT;
        end else if (cx > right_limit) begin
          dir = DIR_RIGHT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ACCUM;
      out_valid   <= 1'b0;
      pixel_tally <= '0;
      sum_columns <= '0;
      sum_rows    <= '0;
      step        <= '0;
    end else begin
      if (out_valid && !out_stall && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        ACCUM: begin
          if (q_pop) begin
            if (q_tag.last) begin
              dvd_x       <= sumc_upd;
              dvd_y       <= sumr_upd;
              divisor     <= tally_upd;
              rem_x       <= '0;
              rem_y       <= '0;
              step        <= '0;
              pixel_tally <= '0;
              sum_columns <= '0;
              sum_rows    <= '0;
              state       <= (tally_upd == '0) ? DONE : DIVIDE;
            end else begin
              pixel_tally <= tally_upd;
              sum_columns <= sumc_upd;
              sum_rows    <= sumr_upd;
            end
          end
        end
        DIVIDE: begin
          rem_x <= ge_x ? TALLY_W'(rsh_x - {1'b0, divisor}) : rsh_x[TALLY_W-1:0];
          rem_y <= ge_y ? TALLY_W'(rsh_y - {1'b0, divisor}) : rsh_y[TALLY_W-1:0];
          dvd_x <= {dvd_x[SUM_W-2:0], ge_x};
          dvd_y <= {dvd_y[SUM_W-2:0], ge_y};
          step  <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (load_out) begin
            out_valid           <= 1'b1;
            out_data.centroid_x <= cx;
            out_data.centroid_y <= cy;
            out_data.red_count  <= divisor;
            out_data.found      <= found;
            out_data.direction  <= dir;
            state               <= ACCUM;
          end
        end
        default: state <= ACCUM;
      endcase
    end
  end

`include "red_pixel_centroid_steering_defines.svh"

  `RPCS_ASSERT_IMP(a_no_pop_busy, state != ACCUM, !q_pop)
  `RPCS_ASSERT_IMP(a_step_bound, state == DIVIDE, step < STEP_W'(SUM_W))
  `RPCS_ASSERT_NEXT(a_load_shows, load_out, out_valid && state == ACCUM)
  `RPCS_ASSERT_IMP(a_empty_zero, out_valid && !out_data.found,
                   out_data.centroid_x == '0 && out_data.direction == DIR_NONE)

endmodule

>>> bench/red_pixel_centroid_steering_check.sv
`timescale 1ns / 100ps

module red_pixel_centroid_steering_check #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  rpcs_pkg::pixel_in_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  rpcs_pkg::result_t                out_data,
  input  logic                             cfg_we,
  input  logic [rpcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rpcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               outstanding,
  output int                               pixels_checked,
  output int                               reports_checked
);
  import rpcs_pkg::*;

  localparam longint unsigned TALLY_CEIL = (64'd1 << TALLY_W) - 1;
  localparam longint unsigned SUM_CEIL   = (64'd1 << SUM_W) - 1;
  localparam longint unsigned COORD_CEIL = (64'd1 << COORD_W) - 1;

  logic [MARGIN_W-1:0]      margin_r;
  logic [FRAME_WIDTH_W-1:0] width_r;
  logic [LIMIT_W-1:0]       left_r;
  logic [LIMIT_W-1:0]       right_r;

  int unsigned     col_r;
  int unsigned     row_r;
  longint unsigned sum_x;
  longint unsigned sum_y;
  longint unsigned tally;

  result_t frame_reports[$];
  int      fail_count;
  int      pixel_count;
  int      report_count;

  function automatic longint unsigned clip_add(input longint unsigned a,
                                               input longint unsigned b,
                                               input longint unsigned ceiling);
    return (a + b > ceiling) ? ceiling : a + b;
  endfunction

  task automatic clear_frame();
    col_r = 0;
    row_r = 0;
    sum_x = 0;
    sum_y = 0;
    tally = 0;
  endtask

  // Accumulate one pixel; on the frame-end pixel queue the report it produces.
  task automatic track_pixel(input pixel_in_t px);
    int unsigned     span;
    bit              hit;
    result_t         rep;
    longint unsigned qx;
    longint unsigned qy;
    span = (width_r == 0) ? 1 : ((width_r > MAX_WIDTH) ? MAX_WIDTH : int'(width_r));
    hit = (int'(px.red) > int'(px.green) + int'(margin_r)) &&
          (int'(px.red) > int'(px.blue) + int'(margin_r));
    if (hit) begin
      tally = clip_add(tally, 1, TALLY_CEIL);
      sum_x = clip_add(sum_x, col_r, SUM_CEIL);
      sum_y = clip_add(sum_y, row_r, SUM_CEIL);
    end
    if (px.frame_end) begin
      rep = '0;
      rep.direction = DIR_NONE;
      if (tally != 0) begin
        qx = sum_x / tally;
        qy = sum_y / tally;
        if (qx > COORD_CEIL) qx = COORD_CEIL;
        if (qy > COORD_CEIL) qy = COORD_CEIL;
        rep.found = 1'b1;
        rep.centroid_x = qx[COORD_W-1:0];
        rep.centroid_y = qy[COORD_W-1:0];
        // steer only with both coordinates off zero; left wins an overlap
        if (qx > 0 && qy > 0) begin
          if (qx < left_r) rep.direction = DIR_LEFT;
          else if (qx > right_r) rep.direction = DIR_RIGHT;
        end
      end
      rep.red_count = tally[TALLY_W-1:0];
      frame_reports.push_back(rep);
      clear_frame();
    end else if (col_r + 1 >= span) begin
      col_r = 0;
      row_r = (row_r + 1 >= MAX_HEIGHT) ? 0 : row_r + 1;
    end else begin
      col_r = col_r + 1;
    end
  endtask

  task automatic compare_report(input result_t got);
    result_t want;
    if (frame_reports.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected frame report: x=%0d y=%0d count=%0d found=%0d dir=%0d",
                 got.centroid_x, got.centroid_y, got.red_count, got.found, got.direction);
      fail_count++;
    end else begin
      want = frame_reports.pop_front();
      if (got.centroid_x !== want.centroid_x || got.centroid_y !== want.centroid_y ||
          got.red_count !== want.red_count || got.found !== want.found ||
          got.direction !== want.direction) begin
        if (fail_count < 10)
          $display("report %0d mismatch: expected x=%0d y=%0d count=%0d found=%0d dir=%0d, %s",
                   report_count, want.centroid_x, want.centroid_y, want.red_count,
                   want.found, want.direction, "see next line");
        if (fail_count < 10)
          $display("  got x=%0d y=%0d count=%0d found=%0d dir=%0d",
                   got.centroid_x, got.centroid_y, got.red_count, got.found, got.direction);
        fail_count++;
      end
    end
    report_count++;
  endtask

  initial begin
    fail_count   = 0;
    pixel_count  = 0;
    report_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      margin_r = RESET_RED_MARGIN;
      width_r  = RESET_FRAME_WIDTH;
      left_r   = RESET_LEFT_LIMIT;
      right_r  = RESET_RIGHT_LIMIT;
      clear_frame();
      frame_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RED_MARGIN:  margin_r = cfg_data[MARGIN_W-1:0];
          REG_FRAME_WIDTH: width_r  = cfg_data[FRAME_WIDTH_W-1:0];
          REG_LEFT_LIMIT:  left_r   = cfg_data[LIMIT_W-1:0];
          REG_RIGHT_LIMIT: right_r  = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        track_pixel(in_data);
        pixel_count++;
      end
      if (out_valid && !out_stall) compare_report(out_data);
    end
    errors          <= fail_count;
    outstanding     <= frame_reports.size();
    pixels_checked  <= pixel_count;
    reports_checked <= report_count;
  end

endmodule

>>> bench/red_pixel_centroid_steering_test.sv
`timescale 1ns / 100ps

module red_pixel_centroid_steering_test;
  import rpcs_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_PAD    = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_PIXELS = 48;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  pixel_in_t              in_data;
  logic                   out_valid;
  logic                   out_stall;
  result_t                out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int errors;
  int outstanding;
  int pixels_checked;
  int reports_checked;

  bit                  calm;
  int                  hold_requests;
  int                  holds_done;
  int                  quiet_cycles;
  int                  setting_count;
  logic [MARGIN_W-1:0] cur_margin;

  red_pixel_centroid_steering #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  red_pixel_centroid_steering_check #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) centroid_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .outstanding(outstanding),
    .pixels_checked(pixels_checked),
    .reports_checked(reports_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random stalls, or one long hold when the stimulus asks for it.
  initial begin
    out_stall <= 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 37);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic pixel_in_t pix(input int b, input int g, input int r, input bit is_last);
    pixel_in_t px;
    px.blue      = 8'(b);
    px.green     = 8'(g);
    px.red       = 8'(r);
    px.frame_end = is_last;
    return px;
  endfunction

  function automatic pixel_in_t make_pixel(input bit is_last);
    pixel_in_t px;
    int        roll;
    int        edge_r;
    roll = $urandom_range(99);
    px.blue      = 8'($urandom);
    px.green     = 8'($urandom);
    px.red       = 8'($urandom);
    px.frame_end = is_last;
    if (roll < 45) begin
      px.red   = 8'($urandom_range(128, 255));
      px.green = 8'($urandom_range(0, 127));
      px.blue  = 8'($urandom_range(0, 127));
    end else if (roll < 60) begin
      // land red right at the margin boundary
      px.blue = 8'($urandom_range(0, px.green));
      edge_r  = int'(px.green) + int'(cur_margin);
      if (edge_r < 255) px.red = 8'(edge_r + $urandom_range(0, 1));
    end
    return px;
  endfunction

  task automatic send_pixel(input pixel_in_t px);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_pixel(make_pixel(i == len - 1));
  endtask

  // Drop valid, wait for every report, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic configure(input int margin, input int width, input int left, input int right);
    settle();
    write_reg(REG_RED_MARGIN, margin);
    write_reg(REG_FRAME_WIDTH, width);
    write_reg(REG_LEFT_LIMIT, left);
    write_reg(REG_RIGHT_LIMIT, right);
    cfg_we <= 1'b0;
    cur_margin = 8'(margin);
    setting_count++;
  endtask

  initial begin
    int longest;
    int sent;
    int len;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    calm          = 1'b0;
    hold_requests = 0;
    setting_count = 1;
    cur_margin    = RESET_RED_MARGIN;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: margin boundary on both sides, red on the frame-end beat, row zero.
    send_pixel(pix(0, 0, 255, 0));
    send_pixel(pix(0, 100, 151, 0));
    send_pixel(pix(0, 100, 152, 0));
    send_pixel(pix(255, 255, 255, 0));
    send_pixel(pix(148, 0, 200, 1));
    // empty frame
    send_pixel(pix(0, 0, 0, 1));

    // overlapping limits: left must win
    configure(0, 3, 1023, 0);
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(5, 5, 5, 0));
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(0, 0, 1, 1));

    // centroid column zero gives no direction, then a right turn
    configure(10, 2, 1, 0);
    send_pixel(pix(0, 0, 255, 0));
    send_pixel(pix(0, 0, 255, 0));
    send_pixel(pix(0, 0, 255, 0));
    send_pixel(pix(10, 10, 21, 1));
    send_pixel(pix(10, 10, 20, 0));
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(255, 0, 255, 0));
    send_pixel(pix(0, 0, 11, 1));

    // narrow the frame while the column counter sits past the new width
    configure(51, 4, 310, 311);
    send_pixel(pix(0, 0, 255, 0));
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 0));
    configure(51, 2, 310, 311);
    send_pixel(pix(0, 0, 255, 0));
    send_pixel(pix(0, 0, 255, 1));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(51, $urandom_range(1, 8), $urandom_range(0, 8), $urandom_range(0, 8));
        1: configure(0, 1, 0, 1023);
        2: configure(255, 1024, 1023, 1023);
        3: configure($urandom_range(0, 80), 2047, $urandom_range(0, 40), $urandom_range(0, 40));
        default: configure($urandom_range(0, 90), $urandom_range(1, 16),
                           $urandom_range(0, 16), $urandom_range(0, 16));
      endcase
      calm = (p == 0);
      longest = (p == 1) ? 3 : 12;
      // short frames under a long output hold back up the block
      if (p == 1) hold_requests++;
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        len = $urandom_range(1, longest);
        send_frame(len);
        sent += len;
      end
      calm = 1'b0;
    end

    // zero width acts as one column, so every beat starts a new row
    configure(30, 0, 0, 0);
    send_frame(20);

    settle();
    $display("Checked %0d pixels and %0d frame reports across %0d register settings,",
             pixels_checked, reports_checked, setting_count);
    $display("with margin, width and limit extremes, a zero width and a long output hold.");
    if (errors == 0 && outstanding == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
